FILE: hdl/skt_pkg.sv
// Package with the shared types, constants and status codes of the sorted key table.
package skt_pkg;

    localparam int SKT_CAPACITY = 8;
    localparam int SKT_KEY_W    = 32;
    localparam int SKT_BYTE_W   = 8;
    localparam int SKT_TOTAL_W  = 4;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_DUP      = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic signed [SKT_KEY_W-1:0]  key;
        logic        [SKT_BYTE_W-1:0] age;
        logic        [SKT_BYTE_W-1:0] children;
    } t_rec;

    typedef struct packed {
        logic cmp;
        logic ins;
        logic del;
        t_rec rec;
    } t_cell_cmd;

endpackage

FILE: hdl/skt_if.sv
// Request and response channel interfaces of the sorted key table.
interface skt_req_if;
    logic                                       valid;
    logic                                       ready;
    logic                                       req_type;
    logic signed [skt_pkg::SKT_KEY_W-1:0]       key;
    logic        [skt_pkg::SKT_BYTE_W-1:0]      age;
    logic        [skt_pkg::SKT_BYTE_W-1:0]      children;

    modport source (output valid, req_type, key, age, children, input ready);
    modport sink (input valid, req_type, key, age, children, output ready);
endinterface

interface skt_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           status;
    logic [skt_pkg::SKT_TOTAL_W-1:0]      entry_total;

    modport source (output valid, status, entry_total, input ready);
    modport sink (input valid, status, entry_total, output ready);
endinterface

FILE: hdl/skt_cell.sv
// One cell of the sorted chain: holds a record and shifts with its neighbors.
module skt_cell (
    input  logic               i_clk,
    input  skt_pkg::t_cell_cmd i_cmd,
    input  logic               i_valid,
    input  logic               i_left_lt,
    input  skt_pkg::t_rec      i_left_rec,
    input  skt_pkg::t_rec      i_right_rec,
    output skt_pkg::t_rec      o_rec,
    output logic               o_lt,
    output logic               o_eq
);
    import skt_pkg::*;

    t_rec r_rec;
    logic r_lt;
    logic r_eq;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp) begin
            r_lt <= i_valid && ($signed(r_rec.key) < $signed(i_cmd.rec.key));
            r_eq <= i_valid && (r_rec.key == i_cmd.rec.key);
        end
        if (i_cmd.ins && !r_lt) begin
            if (i_left_lt) begin
                r_rec <= i_cmd.rec;
            end else begin
                r_rec <= i_left_rec;
            end
        end else if (i_cmd.del && !r_lt) begin
            r_rec <= i_right_rec;
        end
    end

    assign o_rec = r_rec;
    assign o_lt  = r_lt;
    assign o_eq  = r_eq;

endmodule

FILE: hdl/sorted_key_table.sv
// Top level of the sorted key table: control, record count and the chain of cells.
//
// The table holds up to CAPACITY records in ascending order of a signed key.
// Requests arrive on i_req (req_type, key, age, children) and each one yields
// exactly one response on o_rsp (status, entry_total).
// A request is taken when valid and ready are both high; ready is high while
// no request is in progress, also while a response still waits on o_rsp.
// Each request passes through these steps in order: the request is registered,
// every cell compares its stored key with the request key in parallel, and
// the cells shift left or right by one place while the response is loaded
// into the output register. Ready stays low until the response is loaded, so
// a new request is taken only once the current one has gone through every step.
// If the receiver stalls and a response is still held, the update step waits
// until the output register frees; the table is not changed meanwhile.
// Reset clears the record count, so the table starts empty, and drops any
// pending response; no clearing pass is needed.
module sorted_key_table #(
    parameter int CAPACITY = skt_pkg::SKT_CAPACITY
) (
    input logic       i_clk,
    input logic       i_rst_n,
    skt_req_if.sink   i_req,
    skt_rsp_if.source o_rsp
);
    import skt_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_CMP  = 2'd1;
    localparam logic [1:0] PH_UPD  = 2'd2;

    logic [1:0]          r_phase;
    logic [CW-1:0]       r_count;
    logic                r_req_type;
    t_rec                r_req_rec;
    logic                r_out_valid;
    logic [1:0]          r_status;
    logic [CW-1:0]       r_total;

    logic [1:0]          n_status;
    logic [CW-1:0]       n_count;
    logic                n_ins;
    logic                n_del;

    t_cell_cmd           w_cmd;
    t_rec                w_rec [CAPACITY];
    logic [CAPACITY-1:0] w_lt;
    logic [CAPACITY-1:0] w_eq;
    logic                w_found;
    logic                w_full;
    logic                w_upd;

    assign i_req.ready = (r_phase == PH_IDLE);
    assign w_found     = |w_eq;
    assign w_full      = (r_count >= CW'(CAPACITY));
    assign w_upd       = (r_phase == PH_UPD) && !(r_out_valid && !o_rsp.ready);

    always_comb begin
        n_status = ST_DONE;
        n_count  = r_count;
        n_ins    = 1'b0;
        n_del    = 1'b0;
        if (r_req_type == REQ_INSERT) begin
            if (w_full) begin
                n_status = ST_FULL;
            end else if (w_found) begin
                n_status = ST_DUP;
            end else begin
                n_ins   = 1'b1;
                n_count = r_count + CW'(1);
            end
        end else begin
            if (w_found) begin
                n_del   = 1'b1;
                n_count = r_count - CW'(1);
            end else begin
                n_status = ST_NOTFOUND;
            end
        end
    end

    always_comb begin
        w_cmd.cmp = (r_phase == PH_CMP);
        w_cmd.ins = w_upd && n_ins;
        w_cmd.del = w_upd && n_del;
        w_cmd.rec = r_req_rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_rsp.ready && !w_upd) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_req.valid) begin
                        r_phase <= PH_CMP;
                    end
                end
                PH_CMP: begin
                    r_phase <= PH_UPD;
                end
                PH_UPD: begin
                    if (w_upd) begin
                        r_phase     <= PH_IDLE;
                        r_count     <= n_count;
                        r_out_valid <= 1'b1;
                    end
                end
                default: begin
                    r_phase <= PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req_type         <= i_req.req_type;
            r_req_rec.key      <= i_req.key;
            r_req_rec.age      <= i_req.age;
            r_req_rec.children <= i_req.children;
        end
        if (w_upd) begin
            r_status <= n_status;
            r_total  <= n_count;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.entry_total = SKT_TOTAL_W'(r_total);

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic w_left_lt;
            t_rec w_left_rec;
            t_rec w_right_rec;

            if (gi == 0) begin : g_head
                assign w_left_lt  = 1'b1;
                assign w_left_rec = r_req_rec;
            end else begin : g_body
                assign w_left_lt  = w_lt[gi-1];
                assign w_left_rec = w_rec[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_tail
                assign w_right_rec = w_rec[gi];
            end else begin : g_mid
                assign w_right_rec = w_rec[gi+1];
            end

            skt_cell u_cell (
                .i_clk       (i_clk),
                .i_cmd       (w_cmd),
                .i_valid     (CW'(gi) < r_count),
                .i_left_lt   (w_left_lt),
                .i_left_rec  (w_left_rec),
                .i_right_rec (w_right_rec),
                .o_rec       (w_rec[gi]),
                .o_lt        (w_lt[gi]),
                .o_eq        (w_eq[gi])
            );
        end
    endgenerate

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("record count exceeds capacity");

    a_unique_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_UPD) |-> $onehot0(w_eq))
        else $error("more than one cell matches the key");

    a_sorted_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_UPD) |-> (((w_lt >> 1) & ~w_lt) == '0) && ((w_lt & w_eq) == '0))
        else $error("cell order is broken");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_upd && n_ins) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the table");

endmodule

FILE: dv/sorted_key_table_checker.sv
// Response checker of the sorted key table: tracks the record table and compares every response.
`timescale 1ns / 100ps
module sorted_key_table_checker
    import skt_pkg::*;
#(
    parameter int CAPACITY = SKT_CAPACITY
) (
    input  logic i_clk,
    input  logic i_rst_n,
    skt_req_if   i_req,
    skt_rsp_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int PRINT_LIMIT = 100;

    typedef struct packed {
        logic [1:0]             status;
        logic [SKT_TOTAL_W-1:0] entry_total;
    } t_reply;

    t_rec   held_rec [CAPACITY];
    int     held;
    int     errors;
    t_reply replies_due [$];

    function automatic t_reply apply_request(input logic req_type,
                                             input logic signed [SKT_KEY_W-1:0] key,
                                             input logic [SKT_BYTE_W-1:0] age,
                                             input logic [SKT_BYTE_W-1:0] children);
        t_reply rep;
        int     pos;
        int     s;
        pos = 0;
        while (pos < held && $signed(held_rec[pos].key) < $signed(key)) begin
            pos++;
        end
        if (req_type == REQ_INSERT) begin
            if (held >= CAPACITY) begin
                rep.status = ST_FULL;
            end else if (pos < held && held_rec[pos].key == key) begin
                rep.status = ST_DUP;
            end else begin
                for (s = held; s > pos; s--) begin
                    held_rec[s] = held_rec[s - 1];
                end
                held_rec[pos].key      = key;
                held_rec[pos].age      = age;
                held_rec[pos].children = children;
                held++;
                rep.status = ST_DONE;
            end
        end else begin
            if (pos < held && held_rec[pos].key == key) begin
                for (s = pos; s + 1 < held; s++) begin
                    held_rec[s] = held_rec[s + 1];
                end
                held--;
                rep.status = ST_DONE;
            end else begin
                rep.status = ST_NOTFOUND;
            end
        end
        rep.entry_total = SKT_TOTAL_W'(held);
        return rep;
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        o_fail_count <= errors;
        if (errors <= PRINT_LIMIT) begin
            $display("%0t ns sorted_key_table_checker: %s", $time, what);
        end
    endtask

    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            held = 0;
            replies_due.delete();
        end else begin
            if (i_rsp.valid === 1'b1 && i_rsp.ready === 1'b1) begin
                if (replies_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected response: status %0d total %0d",
                                              i_rsp.status, i_rsp.entry_total));
                end else begin
                    want = replies_due.pop_front();
                    if (i_rsp.status !== want.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  i_rsp.status, want.status));
                    end
                    if (i_rsp.entry_total !== want.entry_total) begin
                        report_mismatch($sformatf("entry_total %0d, expected %0d",
                                                  i_rsp.entry_total, want.entry_total));
                    end
                end
            end
            if (i_req.valid === 1'b1 && i_req.ready === 1'b1) begin
                replies_due.push_back(apply_request(i_req.req_type, i_req.key,
                                                    i_req.age, i_req.children));
            end
        end
        o_pending <= replies_due.size();
    end

endmodule

FILE: dv/sorted_key_table_tb.sv
// Testbench top of the sorted key table: clock, reset, request and response traffic, verdict.
`timescale 1ns / 100ps
module sorted_key_table_tb;
    import skt_pkg::*;

    localparam int RANDOM_REQUESTS = 1700;
    localparam int CALM_FIRST      = 700;
    localparam int CALM_LAST       = 1000;
    localparam int STALL_LIMIT     = 1000;
    localparam int POOL_SIZE       = 12;

    localparam logic signed [SKT_KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [SKT_KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

    logic i_clk;
    logic i_rst_n;
    logic calm;
    int   fail_count;
    int   pending;
    int   quiet_cycles;
    logic signed [SKT_KEY_W-1:0] key_pool [POOL_SIZE];

    skt_req_if req_ch ();
    skt_rsp_if rsp_ch ();

    sorted_key_table #(
        .CAPACITY(SKT_CAPACITY)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    sorted_key_table_checker #(
        .CAPACITY(SKT_CAPACITY)
    ) table_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 20);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("sorted_key_table_tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(input logic req_type,
                                input logic signed [SKT_KEY_W-1:0] key,
                                input logic [SKT_BYTE_W-1:0] age,
                                input logic [SKT_BYTE_W-1:0] children);
        if (!calm && $urandom_range(0, 99) < 25) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= req_type;
        req_ch.key      <= key;
        req_ch.age      <= age;
        req_ch.children <= children;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        int                          n;
        int                          insert_pct;
        logic                        req_type;
        logic signed [SKT_KEY_W-1:0] key;

        i_rst_n         <= 1'b0;
        calm            <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= REQ_INSERT;
        req_ch.key      <= '0;
        req_ch.age      <= '0;
        req_ch.children <= '0;

        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MIN + 1;
        key_pool[2] = -1;
        key_pool[3] = 0;
        key_pool[4] = 1;
        key_pool[5] = KEY_MAX - 1;
        key_pool[6] = KEY_MAX;
        for (n = 7; n < POOL_SIZE; n++) begin
            key_pool[n] = $urandom;
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty table, extremes of every field, duplicates, full table and head deletes.
        send_request(REQ_DELETE, 32'sd5, 8'd0, 8'd0);
        send_request(REQ_INSERT, 32'sd0, 8'd0, 8'd0);
        send_request(REQ_INSERT, KEY_MAX, 8'd255, 8'd255);
        send_request(REQ_INSERT, KEY_MIN, 8'd255, 8'd0);
        send_request(REQ_INSERT, -32'sd1, 8'd0, 8'd255);
        send_request(REQ_INSERT, 32'sd0, 8'd17, 8'd3);
        send_request(REQ_INSERT, KEY_MIN, 8'd1, 8'd1);
        send_request(REQ_DELETE, 32'sd7, 8'd0, 8'd0);
        send_request(REQ_DELETE, KEY_MIN, 8'd0, 8'd0);
        send_request(REQ_DELETE, KEY_MAX, 8'd0, 8'd0);
        send_request(REQ_DELETE, 32'sd0, 8'd0, 8'd0);
        send_request(REQ_INSERT, KEY_MIN, 8'd10, 8'd20);
        send_request(REQ_INSERT, KEY_MAX, 8'd30, 8'd40);
        send_request(REQ_INSERT, 32'sd0, 8'd50, 8'd60);
        send_request(REQ_INSERT, 32'sd1, 8'd70, 8'd80);
        send_request(REQ_INSERT, 32'sd100, 8'd90, 8'd100);
        send_request(REQ_INSERT, -32'sd100, 8'd110, 8'd120);
        send_request(REQ_INSERT, 32'sd5, 8'd130, 8'd140);
        send_request(REQ_INSERT, 32'sd6, 8'd150, 8'd160);
        send_request(REQ_INSERT, -32'sd1, 8'd170, 8'd180);
        send_request(REQ_DELETE, 32'sd100, 8'd0, 8'd0);
        send_request(REQ_DELETE, KEY_MIN, 8'd0, 8'd0);
        send_request(REQ_INSERT, KEY_MIN + 1, 8'd190, 8'd200);
        send_request(REQ_DELETE, 32'sd6, 8'd0, 8'd0);
        send_request(REQ_DELETE, -32'sd1, 8'd0, 8'd0);

        insert_pct = 50;
        for (n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 100 == 0) begin
                insert_pct = $urandom_range(25, 85);
            end
            calm <= (n >= CALM_FIRST && n < CALM_LAST);
            req_type = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_DELETE;
            if ($urandom_range(0, 99) < 85) begin
                key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            end else begin
                key = $urandom;
            end
            send_request(req_type, key, SKT_BYTE_W'($urandom_range(0, 255)),
                         SKT_BYTE_W'($urandom_range(0, 255)));
        end
        req_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("sorted_key_table_tb: PASS");
        end else begin
            $display("sorted_key_table_tb: FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/skt_pkg.sv
hdl/skt_if.sv
hdl/skt_cell.sv
hdl/sorted_key_table.sv
dv/sorted_key_table_checker.sv
dv/sorted_key_table_tb.sv
